// ===== rtl/mtw_pkg.sv =====
package mtw_pkg;

  typedef enum logic [1:0] {
    ST_PARSE,
    ST_ERROR,
    ST_SEND
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_LOW,
    PH_COLON,
    PH_DONE
  } phase_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_SHORT    = 2'd2;

  localparam int unsigned ADDR_LEN   = 6;
  localparam int unsigned SYNC_WORDS = 3;
  localparam int unsigned ADDR_WORDS = 3;

  localparam logic [15:0] SYNC_WORD  = 16'hffff;
  localparam logic [7:0]  CHAR_END   = 8'h00;
  localparam logic [7:0]  CHAR_COLON = 8'h3a;

  typedef struct packed {
    logic parse;      // non-terminating character accepted
    logic finish;     // terminating character accepted
    logic load_err;   // load error result into output register
    logic load_word;  // load next packet word into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic char_zero;
    logic fail;
    logic last_word;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/mtw_char_if.sv =====
interface mtw_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// ===== rtl/mtw_word_if.sv =====
interface mtw_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_word;
  logic        last_word;
  logic [1:0]  status;

  modport source (output valid, output packet_word, output last_word, output status,
                  input ready);
  modport sink   (input valid, input packet_word, input last_word, input status,
                  output ready);
endinterface

// ===== rtl/mtw_ctrl.sv =====
module mtw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtw_pkg::dp_status_t status_i,
  output mtw_pkg::ctrl_cmd_t  cmd_o
);

  mtw_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtw_pkg::ST_PARSE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mtw_pkg::ST_PARSE: begin
        if (in_valid_i && status_i.char_zero) begin
          state_d = status_i.fail ? mtw_pkg::ST_ERROR : mtw_pkg::ST_SEND;
        end
      end
      mtw_pkg::ST_ERROR: begin
        if (status_i.out_free) begin
          state_d = mtw_pkg::ST_PARSE;
        end
      end
      mtw_pkg::ST_SEND: begin
        if (status_i.out_free && status_i.last_word) begin
          state_d = mtw_pkg::ST_PARSE;
        end
      end
      default: state_d = mtw_pkg::ST_PARSE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      mtw_pkg::ST_PARSE: begin
        in_ready_o   = 1'b1;
        cmd_o.parse  = in_valid_i && !status_i.char_zero;
        cmd_o.finish = in_valid_i && status_i.char_zero;
      end
      mtw_pkg::ST_ERROR: begin
        cmd_o.load_err = status_i.out_free;
      end
      mtw_pkg::ST_SEND: begin
        cmd_o.load_word = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/mtw_datapath.sv =====
module mtw_datapath #(
  parameter int unsigned REPEATS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         char_code_i,
  input  mtw_pkg::ctrl_cmd_t  cmd_i,
  output mtw_pkg::dp_status_t status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        packet_word_o,
  output logic               last_word_o,
  output logic [1:0]         status_code_o
);

  localparam int unsigned NWORDS = mtw_pkg::SYNC_WORDS + mtw_pkg::ADDR_WORDS * REPEATS;
  localparam int unsigned CW     = $clog2(NWORDS);

  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] res;
    res = '0;
    if (ch inside {[8'h30:8'h39]}) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch inside {[8'h61:8'h66]}) begin
      res = {1'b1, 4'(ch - 8'h57)};
    end else if (ch inside {[8'h41:8'h46]}) begin
      res = {1'b1, 4'(ch - 8'h37)};
    end
    return res;
  endfunction

  mtw_pkg::phase_e phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [2:0]  count_q, count_d;
  logic        bad_q, bad_d;
  logic [1:0]  err_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]  pair_q;
  logic [15:0] addr_q [mtw_pkg::ADDR_WORDS];

  logic        out_valid_q;
  logic [15:0] out_word_q;
  logic        out_last_q;
  logic [1:0]  out_status_q;

  logic [4:0]  hex;
  logic        is_colon;
  logic        start_byte;
  logic        wr_en;
  logic [7:0]  wr_val;
  logic [2:0]  count_after;
  logic        is_last;
  logic        is_sync;

  assign hex      = hex_decode(char_code_i);
  assign is_colon = (char_code_i == mtw_pkg::CHAR_COLON);

  always_comb begin
    phase_d    = phase_q;
    nib_d      = nib_q;
    count_d    = count_q;
    bad_d      = bad_q;
    wr_en      = 1'b0;
    wr_val     = '0;
    start_byte = 1'b0;
    if (cmd_i.finish) begin
      if (phase_q == mtw_pkg::PH_LOW && !bad_q) begin
        wr_en  = 1'b1;
        wr_val = {4'h0, nib_q};
      end
      phase_d = mtw_pkg::PH_HIGH;
      nib_d   = '0;
      count_d = '0;
      bad_d   = 1'b0;
    end else if (cmd_i.parse && !bad_q && phase_q != mtw_pkg::PH_DONE) begin
      case (phase_q)
        mtw_pkg::PH_LOW: begin
          if (hex[4]) begin
            wr_en  = 1'b1;
            wr_val = {nib_q, hex[3:0]};
          end else if (is_colon) begin
            wr_en  = 1'b1;
            wr_val = {4'h0, nib_q};
          end else begin
            bad_d = 1'b1;
          end
        end
        mtw_pkg::PH_COLON: begin
          if (is_colon) begin
            phase_d = mtw_pkg::PH_HIGH;
          end else begin
            start_byte = 1'b1;
          end
        end
        default: start_byte = 1'b1;
      endcase
      if (start_byte) begin
        if (hex[4]) begin
          nib_d   = hex[3:0];
          phase_d = mtw_pkg::PH_LOW;
        end else begin
          bad_d = 1'b1;
        end
      end
      if (wr_en) begin
        count_d = count_q + 3'd1;
        phase_d = (count_q == 3'(mtw_pkg::ADDR_LEN - 1)) ? mtw_pkg::PH_DONE
                                                          : mtw_pkg::PH_COLON;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtw_pkg::PH_HIGH;
      nib_q   <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      count_q <= count_d;
      bad_q   <= bad_d;
    end
  end

  // address bytes, packed two per word in packet order
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (!count_q[0]) begin
        addr_q[count_q[2:1]][15:8] <= wr_val;
      end else begin
        addr_q[count_q[2:1]][7:0] <= wr_val;
      end
    end
  end

  assign count_after = count_q + {2'b00, (phase_q == mtw_pkg::PH_LOW) && !bad_q};
  assign is_last     = (cnt_q == CW'(NWORDS - 1));
  assign is_sync     = (cnt_q < CW'(mtw_pkg::SYNC_WORDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= mtw_pkg::STATUS_OK;
      cnt_q  <= '0;
      pair_q <= '0;
    end else if (cmd_i.finish) begin
      err_q  <= bad_q ? mtw_pkg::STATUS_BAD_CHAR : mtw_pkg::STATUS_SHORT;
      cnt_q  <= '0;
      pair_q <= '0;
    end else if (cmd_i.load_word) begin
      cnt_q <= cnt_q + CW'(1);
      if (!is_sync) begin
        pair_q <= (pair_q == 2'(mtw_pkg::ADDR_WORDS - 1)) ? 2'd0 : pair_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.load_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_word_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= err_q;
    end else if (cmd_i.load_word) begin
      out_word_q   <= is_sync ? mtw_pkg::SYNC_WORD : addr_q[pair_q];
      out_last_q   <= is_last;
      out_status_q <= mtw_pkg::STATUS_OK;
    end
  end

  assign status_o.char_zero = (char_code_i == mtw_pkg::CHAR_END);
  assign status_o.fail      = bad_q || (count_after != 3'(mtw_pkg::ADDR_LEN));
  assign status_o.last_word = is_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign packet_word_o = out_word_q;
  assign last_word_o   = out_last_q;
  assign status_code_o = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(mtw_pkg::ADDR_LEN))
    else $error("byte count out of range");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == mtw_pkg::PH_DONE |-> count_q == 3'(mtw_pkg::ADDR_LEN))
    else $error("done phase without six bytes");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != mtw_pkg::STATUS_OK |-> out_last_q && out_word_q == '0)
    else $error("error result not a single zero word");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cmd_i.load_err || cmd_i.load_word) && (cmd_i.parse || cmd_i.finish)))
    else $error("parse and output load in the same cycle");

endmodule

// ===== rtl/mac_text_to_wake_packet_top.sv =====
// After the terminating character is accepted, the send or error state loads
// the first result word into the output register. Throughput: one character
// per cycle while parsing; the terminating character is followed by 3 + 3*REPEATS
// words (51 at REPEATS=16) or one error word, one per cycle unless the output
// stalls, during which no input is taken. The single output register sets this.
// Reset clears parse state and output valid; address bytes are kept.
module mac_text_to_wake_packet_top #(
  parameter int unsigned REPEATS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mtw_char_if.sink          char_i,
  mtw_word_if.source        word_o
);

  mtw_pkg::ctrl_cmd_t  cmd;
  mtw_pkg::dp_status_t status;

  mtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtw_datapath #(
    .REPEATS (REPEATS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (char_i.char_code),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (word_o.valid),
    .out_ready_i   (word_o.ready),
    .packet_word_o (word_o.packet_word),
    .last_word_o   (word_o.last_word),
    .status_code_o (word_o.status)
  );

endmodule
